>>> rtl/core/i2cmts_pkg.sv
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Shared types and codes of the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

    // command codes (input tuser)
    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_STATUS = 2'd1;
    localparam logic [1:0] CMD_STOPPED = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    // engine action codes (output tuser)
    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_STOP = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_ADDR = 3'd3;
    localparam logic [2:0] ACT_ACK  = 3'd4;
    localparam logic [2:0] ACT_NACK = 3'd5;
    localparam logic [2:0] ACT_BYTE = 3'd6;

    // engine status bytes
    localparam logic [7:0] ST_START_SENT  = 8'h08;
    localparam logic [7:0] ST_RSTART_SENT = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
    localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
    localparam logic [7:0] ST_RX_ACK      = 8'h50;
    localparam logic [7:0] ST_RX_NACK     = 8'h58;
    localparam logic [7:0] ST_TX_ACK      = 8'h28;

    localparam logic [7:0] TIMEOUT_RESET = 8'd10;
    localparam logic [7:0] TICKS_MAX     = 8'hFF;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  dev_address;
        logic        read_not_write;
        logic [15:0] transfer_length;
        logic [7:0]  status_code;
        logic [7:0]  received_byte;
        logic [7:0]  tx_byte;
    } t_item;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] out_byte;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       done_res;
        logic       ack;
        logic       busy_res;
    } t_result;

endpackage

>>> rtl/core/i2c_master_transaction_sequencer_core.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_core
// Sequences one I2C master read or write over a byte-level bus engine.
//
//   channel   dir  handshake            payload
//   s (event) in   tvalid/tready        tuser cmd, tdata item fields
//   m (step)  out  tvalid/tready        tuser action, tdata result fields
//   cfg       in   we only              timeout_ticks
//
// One word in per cycle while the result register is free, one result word out per input word.
// Each word passes the input register, then the result register.
// The transfer state updates when the input word moves into the result register.
// A stalled output holds the result; the input register still takes one word.
// Reset is synchronous; the timeout returns to 10 ticks.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_core #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [7:0]                        i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [1:0] cmd
    input  logic [1:0]                        i_s_tuser,
    // [7:0] dev_address, [8] read_not_write, [24:9] transfer_length,
    // [32:25] status_code, [40:33] received_byte, [48:41] tx_byte
    input  logic [i2cmts_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [2:0] action
    output logic [2:0]                        o_m_tuser,
    // [7:0] out_byte, [8] rx_valid, [16:9] rx_data, [17] done_res,
    // [18] ack, [19] busy_res
    output logic [i2cmts_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    i2cmts_pkg::t_item   w_s_item;
    i2cmts_pkg::t_item   w_item;
    i2cmts_pkg::t_result w_step;
    i2cmts_pkg::t_result w_out;
    logic                w_in_valid;
    logic                w_out_free;
    logic                w_adv;

    assign w_s_item.cmd             = i_s_tuser;
    assign w_s_item.dev_address     = i_s_tdata[7:0];
    assign w_s_item.read_not_write  = i_s_tdata[8];
    assign w_s_item.transfer_length = i_s_tdata[24:9];
    assign w_s_item.status_code     = i_s_tdata[32:25];
    assign w_s_item.received_byte   = i_s_tdata[40:33];
    assign w_s_item.tx_byte         = i_s_tdata[48:41];

    assign w_adv = w_in_valid && w_out_free;

    i2cmts_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (w_s_item),
        .i_adv   (w_adv),
        .o_valid (w_in_valid),
        .o_item  (w_item)
    );

    i2cmts_fsm #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (w_adv),
        .i_item      (w_item),
        .o_result    (w_step)
    );

    i2cmts_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_adv),
        .i_result (w_step),
        .o_free   (w_out_free),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_out)
    );

    assign o_m_tuser = w_out.action;
    assign o_m_tdata = {4'd0, w_out.busy_res, w_out.ack, w_out.done_res,
                        w_out.rx_data, w_out.rx_valid, w_out.out_byte};
endmodule

>>> rtl/core/i2cmts_in_stage.sv
// ----------------------------------------------------------------------------
// i2cmts_in_stage
// Input register: captures one accepted word and holds it until it is used.
// ----------------------------------------------------------------------------
module i2cmts_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  i2cmts_pkg::t_item   i_item,
    input  logic                i_adv,
    output logic                o_valid,
    output i2cmts_pkg::t_item   o_item
);
    logic              r_valid;
    logic              n_valid;
    i2cmts_pkg::t_item r_item;
    logic              w_take;

    assign o_ready = !r_valid || i_adv;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

>>> rtl/core/i2cmts_fsm.sv
// ----------------------------------------------------------------------------
// i2cmts_fsm
// Transfer state and the one-step next-state / result logic.
// ----------------------------------------------------------------------------
module i2cmts_fsm #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_adv,
    input  i2cmts_pkg::t_item   i_item,
    output i2cmts_pkg::t_result o_result
);
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_PRESTOP   = 3'd1;
    localparam logic [2:0] PH_START     = 3'd2;
    localparam logic [2:0] PH_ADDR      = 3'd3;
    localparam logic [2:0] PH_DATA      = 3'd4;
    localparam logic [2:0] PH_STOP_OK   = 3'd5;
    localparam logic [2:0] PH_STOP_FAIL = 3'd6;

    localparam logic [LENGTH_WIDTH-1:0] LEN_ONE = LENGTH_WIDTH'(1);

    logic [7:0]              r_timeout;
    logic [2:0]              r_phase,      n_phase;
    logic [LENGTH_WIDTH-1:0] r_bytes_left, n_bytes_left;
    logic                    r_is_read,    n_is_read;
    logic [7:0]              r_addr_byte,  n_addr_byte;
    logic [7:0]              r_wait,       n_wait;
    logic                    r_ack_flag,   n_ack_flag;

    logic [LENGTH_WIDTH-1:0] w_len;
    logic [LENGTH_WIDTH-1:0] w_dec;
    logic [7:0]              w_wait_inc;
    logic                    w_bad;
    logic                    w_ok;
    i2cmts_pkg::t_result     w_res;

    assign w_len      = LENGTH_WIDTH'(i_item.transfer_length);
    assign w_dec      = r_bytes_left - LEN_ONE;
    assign w_wait_inc = (r_wait == i2cmts_pkg::TICKS_MAX) ? r_wait : r_wait + 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_is_read    = r_is_read;
        n_addr_byte  = r_addr_byte;
        n_wait       = r_wait;
        n_ack_flag   = r_ack_flag;
        w_bad        = 1'b0;
        w_ok         = 1'b0;
        w_res        = '0;

        case (i_item.cmd)
            i2cmts_pkg::CMD_BEGIN: begin
                if (r_phase == PH_IDLE) begin
                    if (w_len == '0) begin
                        w_res.done_res = 1'b1;
                    end else begin
                        n_bytes_left = w_len;
                        n_is_read    = i_item.read_not_write;
                        n_addr_byte  = i_item.dev_address;
                        w_res.action = i2cmts_pkg::ACT_STOP;
                        n_phase      = PH_PRESTOP;
                        n_wait       = '0;
                    end
                end
            end
            i2cmts_pkg::CMD_STATUS: begin
                case (r_phase)
                    PH_START: begin
                        if (i_item.status_code == i2cmts_pkg::ST_START_SENT ||
                            i_item.status_code == i2cmts_pkg::ST_RSTART_SENT) begin
                            w_res.action   = i2cmts_pkg::ACT_ADDR;
                            w_res.out_byte = r_addr_byte | {7'd0, r_is_read};
                            n_phase        = PH_ADDR;
                            n_wait         = '0;
                        end else begin
                            w_bad = 1'b1;
                        end
                    end
                    PH_ADDR: begin
                        if (i_item.status_code == i2cmts_pkg::ST_SLA_W_ACK ||
                            i_item.status_code == i2cmts_pkg::ST_SLA_R_ACK) begin
                            if (r_is_read) begin
                                w_res.action = (r_bytes_left == LEN_ONE) ?
                                               i2cmts_pkg::ACT_NACK : i2cmts_pkg::ACT_ACK;
                            end else begin
                                w_res.action   = i2cmts_pkg::ACT_BYTE;
                                w_res.out_byte = i_item.tx_byte;
                            end
                            n_phase = PH_DATA;
                            n_wait  = '0;
                        end else begin
                            w_bad = 1'b1;
                        end
                    end
                    PH_DATA: begin
                        w_ok = r_is_read ?
                               (i_item.status_code == i2cmts_pkg::ST_RX_ACK ||
                                i_item.status_code == i2cmts_pkg::ST_RX_NACK) :
                               (i_item.status_code == i2cmts_pkg::ST_TX_ACK);
                        if (!w_ok) begin
                            w_bad = 1'b1;
                        end else begin
                            if (r_is_read) begin
                                w_res.rx_valid = 1'b1;
                                w_res.rx_data  = i_item.received_byte;
                            end
                            n_bytes_left = w_dec;
                            n_wait       = '0;
                            if (w_dec == '0) begin
                                w_res.action = i2cmts_pkg::ACT_STOP;
                                n_phase      = PH_STOP_OK;
                            end else if (r_is_read) begin
                                w_res.action = (w_dec == LEN_ONE) ?
                                               i2cmts_pkg::ACT_NACK : i2cmts_pkg::ACT_ACK;
                            end else begin
                                w_res.action   = i2cmts_pkg::ACT_BYTE;
                                w_res.out_byte = i_item.tx_byte;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            i2cmts_pkg::CMD_STOPPED: begin
                case (r_phase)
                    PH_PRESTOP: begin
                        w_res.action = i2cmts_pkg::ACT_START;
                        n_phase      = PH_START;
                        n_wait       = '0;
                    end
                    PH_STOP_OK: begin
                        w_res.done_res = 1'b1;
                        n_ack_flag     = 1'b1;
                        n_phase        = PH_IDLE;
                        n_wait         = '0;
                    end
                    PH_STOP_FAIL: begin
                        w_res.done_res = 1'b1;
                        n_ack_flag     = 1'b0;
                        n_phase        = PH_IDLE;
                        n_wait         = '0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                // timer tick
                if (r_phase != PH_IDLE) begin
                    n_wait = w_wait_inc;
                    if (w_wait_inc >= r_timeout) begin
                        if (r_phase == PH_START || r_phase == PH_ADDR ||
                            r_phase == PH_DATA) begin
                            w_bad = 1'b1;
                        end else begin
                            w_res.done_res = 1'b1;
                            n_ack_flag     = 1'b0;
                            n_phase        = PH_IDLE;
                            n_wait         = '0;
                        end
                    end
                end
            end
        endcase

        // bad status or flag timeout: issue STOP, then fail
        if (w_bad) begin
            w_res.action   = i2cmts_pkg::ACT_STOP;
            w_res.out_byte = '0;
            n_phase        = PH_STOP_FAIL;
            n_wait         = '0;
        end

        w_res.ack      = n_ack_flag;
        w_res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= i2cmts_pkg::TIMEOUT_RESET;
            r_phase      <= PH_IDLE;
            r_bytes_left <= '0;
            r_is_read    <= 1'b0;
            r_addr_byte  <= '0;
            r_wait       <= '0;
            r_ack_flag   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_adv) begin
                r_phase      <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_is_read    <= n_is_read;
                r_addr_byte  <= n_addr_byte;
                r_wait       <= n_wait;
                r_ack_flag   <= n_ack_flag;
            end
        end
    end

    assign o_result = w_res;
endmodule

>>> rtl/core/i2cmts_out_stage.sv
// ----------------------------------------------------------------------------
// i2cmts_out_stage
// Result register toward the master-side stream.
// ----------------------------------------------------------------------------
module i2cmts_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  i2cmts_pkg::t_result i_result,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output i2cmts_pkg::t_result o_result
);
    logic                r_valid;
    logic                n_valid;
    i2cmts_pkg::t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

>>> rtl/core/i2cmts_checker.sv
// ----------------------------------------------------------------------------
// i2cmts_checker
// Port-level checks of the transaction sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmts_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [2:0]                        o_m_tuser,
    input logic [i2cmts_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    // no result word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word valid after reset");

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result word changed");

    // out_byte only carries data on address or byte loads
    a_obyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != i2cmts_pkg::ACT_ADDR &&
            o_m_tuser != i2cmts_pkg::ACT_BYTE |-> o_m_tdata[7:0] == 8'd0)
        else $error("out_byte set without a load action");

    // a finished transfer leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[17] |-> !o_m_tdata[19] &&
            o_m_tuser == i2cmts_pkg::ACT_NONE)
        else $error("done while still busy or with an action");

    // received data is zero unless flagged
    a_rx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[8] |-> o_m_tdata[16:9] == 8'd0)
        else $error("rx_data set without rx_valid");
endmodule

bind i2c_master_transaction_sequencer_core i2cmts_checker u_i2cmts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tuser  (o_m_tuser),
    .o_m_tdata  (o_m_tdata)
);

>>> tb/sv/i2cmts_step_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2cmts_step_checker
// Watches the event and step streams of the I2C transaction sequencer, keeps
// its own copy of the transfer state, predicts one step word per event word
// and compares every accepted step word with the oldest prediction.
// ----------------------------------------------------------------------------
module i2cmts_step_checker
    import i2cmts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [1:0]            i_s_tuser,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [2:0]            i_m_tuser,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_acked,
    output int                    o_failed
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRESTOP,
        PH_START,
        PH_ADDR,
        PH_DATA,
        PH_STOP_OK,
        PH_STOP_FAIL
    } t_phase;

    t_phase      phase;
    logic [15:0] bytes_left;
    logic        is_read;
    logic [7:0]  addr_byte;
    logic [7:0]  wait_ticks;
    logic [7:0]  timeout_ticks;
    logic        ack_flag;

    t_result     expected_steps[$];
    int          err_count;
    int          check_count;
    int          ack_count;
    int          fail_count;

    initial begin
        err_count   = 0;
        check_count = 0;
        ack_count   = 0;
        fail_count  = 0;
    end

    // every new wait starts its tick count from zero
    task automatic enter_phase(input t_phase p);
        phase      = p;
        wait_ticks = '0;
    endtask

    task automatic advance_sequencer(input t_item it, output t_result r);
        logic bad;
        logic good;
        r   = '0;
        bad = 1'b0;
        case (it.cmd)
            CMD_BEGIN: begin
                if (phase == PH_IDLE) begin
                    if (it.transfer_length == '0) begin
                        r.done_res = 1'b1;
                    end else begin
                        bytes_left = it.transfer_length;
                        is_read    = it.read_not_write;
                        addr_byte  = it.dev_address;
                        r.action   = ACT_STOP;
                        enter_phase(PH_PRESTOP);
                    end
                end
            end
            CMD_STATUS: begin
                case (phase)
                    PH_START: begin
                        if (it.status_code == ST_START_SENT ||
                            it.status_code == ST_RSTART_SENT) begin
                            r.action   = ACT_ADDR;
                            r.out_byte = addr_byte | {7'd0, is_read};
                            enter_phase(PH_ADDR);
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    PH_ADDR: begin
                        if (it.status_code == ST_SLA_W_ACK ||
                            it.status_code == ST_SLA_R_ACK) begin
                            if (is_read) begin
                                r.action = (bytes_left == 16'd1) ? ACT_NACK : ACT_ACK;
                            end else begin
                                r.action   = ACT_BYTE;
                                r.out_byte = it.tx_byte;
                            end
                            enter_phase(PH_DATA);
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    PH_DATA: begin
                        good = is_read ? (it.status_code == ST_RX_ACK ||
                                          it.status_code == ST_RX_NACK)
                                       : (it.status_code == ST_TX_ACK);
                        if (!good) begin
                            bad = 1'b1;
                        end else begin
                            if (is_read) begin
                                r.rx_valid = 1'b1;
                                r.rx_data  = it.received_byte;
                            end
                            bytes_left = bytes_left - 16'd1;
                            if (bytes_left == '0) begin
                                r.action = ACT_STOP;
                                enter_phase(PH_STOP_OK);
                            end else if (is_read) begin
                                r.action = (bytes_left == 16'd1) ? ACT_NACK : ACT_ACK;
                                enter_phase(PH_DATA);
                            end else begin
                                r.action   = ACT_BYTE;
                                r.out_byte = it.tx_byte;
                                enter_phase(PH_DATA);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            CMD_STOPPED: begin
                case (phase)
                    PH_PRESTOP: begin
                        r.action = ACT_START;
                        enter_phase(PH_START);
                    end
                    PH_STOP_OK: begin
                        r.done_res = 1'b1;
                        ack_flag   = 1'b1;
                        enter_phase(PH_IDLE);
                    end
                    PH_STOP_FAIL: begin
                        r.done_res = 1'b1;
                        ack_flag   = 1'b0;
                        enter_phase(PH_IDLE);
                    end
                    default: ;
                endcase
            end
            default: begin
                if (phase != PH_IDLE) begin
                    if (wait_ticks != TICKS_MAX)
                        wait_ticks = wait_ticks + 8'd1;
                    if (wait_ticks >= timeout_ticks) begin
                        // a stuck engine flag is handled like a bad status
                        if (phase inside {PH_START, PH_ADDR, PH_DATA}) begin
                            bad = 1'b1;
                        end else begin
                            r.done_res = 1'b1;
                            ack_flag   = 1'b0;
                            enter_phase(PH_IDLE);
                        end
                    end
                end
            end
        endcase

        if (bad) begin
            r.action   = ACT_STOP;
            r.out_byte = '0;
            enter_phase(PH_STOP_FAIL);
        end
        r.ack      = ack_flag;
        r.busy_res = (phase != PH_IDLE);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_item   it;
        t_result got;
        t_result want;
        t_result pred;
        if (!i_rst_n) begin
            timeout_ticks = TIMEOUT_RESET;
            phase         = PH_IDLE;
            bytes_left    = '0;
            is_read       = 1'b0;
            addr_byte     = '0;
            wait_ticks    = '0;
            ack_flag      = 1'b0;
            expected_steps.delete();
        end else begin
            if (i_cfg_we)
                timeout_ticks = i_cfg_wdata;

            // compare before queuing so a fresh prediction never covers a stray word
            if (i_m_tvalid && i_m_tready) begin
                got.action   = i_m_tuser;
                got.out_byte = i_m_tdata[7:0];
                got.rx_valid = i_m_tdata[8];
                got.rx_data  = i_m_tdata[16:9];
                got.done_res = i_m_tdata[17];
                got.ack      = i_m_tdata[18];
                got.busy_res = i_m_tdata[19];
                if (expected_steps.size() == 0) begin
                    err_count++;
                    $display("%0t: step word with nothing expected, action %h data %h",
                             $time, i_m_tuser, i_m_tdata);
                end else begin
                    want = expected_steps.pop_front();
                    compare_field("action", {5'd0, want.action}, {5'd0, got.action});
                    compare_field("out_byte", want.out_byte, got.out_byte);
                    compare_field("rx_valid", {7'd0, want.rx_valid}, {7'd0, got.rx_valid});
                    compare_field("rx_data", want.rx_data, got.rx_data);
                    compare_field("done_res", {7'd0, want.done_res}, {7'd0, got.done_res});
                    compare_field("ack", {7'd0, want.ack}, {7'd0, got.ack});
                    compare_field("busy_res", {7'd0, want.busy_res}, {7'd0, got.busy_res});
                    check_count++;
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                it.cmd             = i_s_tuser;
                it.dev_address     = i_s_tdata[7:0];
                it.read_not_write  = i_s_tdata[8];
                it.transfer_length = i_s_tdata[24:9];
                it.status_code     = i_s_tdata[32:25];
                it.received_byte   = i_s_tdata[40:33];
                it.tx_byte         = i_s_tdata[48:41];
                advance_sequencer(it, pred);
                if (pred.done_res) begin
                    if (pred.ack)
                        ack_count++;
                    else
                        fail_count++;
                end
                expected_steps.push_back(pred);
            end
        end
        o_errors  <= err_count;
        o_pending <= expected_steps.size();
        o_checked <= check_count;
        o_acked   <= ack_count;
        o_failed  <= fail_count;
    end

endmodule

>>> tb/sv/tb_i2c_master_transaction_sequencer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_transaction_sequencer_core
// Drives begin, status, stop-done and tick words into the sequencer: a short
// directed part, then mostly well-formed read and write transfers with random
// content, faults, timeouts and stray events, under several timeout settings.
// Both streams idle and stall at random; the step checker does the comparing.
// ----------------------------------------------------------------------------
module tb_i2c_master_transaction_sequencer_core;
    import i2cmts_pkg::*;

    localparam int LIMIT        = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int WORD_BUDGET  = 750;
    localparam int N_SETTINGS   = 6;
    localparam int MAX_DATA     = 8;
    // event positions inside one transfer
    localparam int STEP_PRESTOP = 1;
    localparam int STEP_START   = 2;
    localparam int STEP_ADDR    = 3;
    localparam int STEP_DATA0   = 4;

    typedef enum {FLT_BAD_STATUS, FLT_TIMEOUT} t_fault;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [7:0]            cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [1:0]            s_tuser   = '0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [2:0]            m_tuser;
    logic [OUT_DATA_W-1:0] m_tdata;

    int         errors;
    int         pending;
    int         checked;
    int         acked;
    int         failed;
    int         cycles        = 0;
    int         words_sent    = 0;
    logic [7:0] timeout_now   = TIMEOUT_RESET;
    bit         send_steady   = 1'b0;
    bit         noise_on      = 1'b0;
    bit         hold_off_req  = 1'b0;
    int         tmo_plan[N_SETTINGS];

    i2c_master_transaction_sequencer_core #(
        .LENGTH_WIDTH(16)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tuser   (s_tuser),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tuser   (m_tuser),
        .o_m_tdata   (m_tdata)
    );

    i2cmts_step_checker u_step_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tuser   (s_tuser),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tuser   (m_tuser),
        .i_m_tdata   (m_tdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_acked     (acked),
        .o_failed    (failed)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("i2c_master_transaction_sequencer_core test failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none at all in a steady stretch
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_item any_item(input logic [1:0] cmd);
        t_item it;
        it.cmd             = cmd;
        it.dev_address     = 8'($urandom_range(0, 255));
        it.read_not_write  = 1'($urandom_range(0, 1));
        it.transfer_length = 16'($urandom_range(0, 65535));
        it.status_code     = 8'($urandom_range(0, 255));
        it.received_byte   = 8'($urandom_range(0, 255));
        it.tx_byte         = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // hold the word until the block takes it; valid stays up for the next word
    task automatic send_word(input t_item it, input bit counts);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        gap = pick_gap(send_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {7'd0, it.tx_byte, it.received_byte, it.status_code,
                     it.transfer_length, it.read_not_write, it.dev_address};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (counts)
            words_sent++;
    endtask

    task automatic send_status(input logic [7:0] st);
        t_item it;
        it = any_item(CMD_STATUS);
        it.status_code = st;
        send_word(it, 1'b1);
    endtask

    task automatic send_ticks(input int n);
        for (int k = 0; k < n; k++)
            send_word(any_item(CMD_TICK), 1'b1);
    endtask

    task automatic send_zero_begin();
        t_item it;
        it = any_item(CMD_BEGIN);
        it.transfer_length = '0;
        send_word(it, 1'b1);
    endtask

    // drop valid and wait until every step word has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_timeout(input logic [7:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        timeout_now = v;
    endtask

    // One transfer: begin, pre-stop done, start status, address status, data
    // statuses, final stop done. A fault at fault_at (0 for none) replaces that
    // event by a bad status or by ticks up to the timeout, then drains the STOP.
    task automatic run_transfer(input logic [7:0] dev, input logic rnw,
                                input logic [15:0] len, input int fault_at,
                                input t_fault kind);
        t_item      it;
        t_item      stray;
        int         n_data;
        int         last_idx;
        int         hi;
        bit         stop_wait;
        logic [7:0] st;
        it = any_item(CMD_BEGIN);
        it.dev_address     = dev;
        it.read_not_write  = rnw;
        it.transfer_length = len;
        send_word(it, 1'b1);
        if (len == '0)
            return;
        n_data   = (int'(len) > MAX_DATA) ? MAX_DATA : int'(len);
        last_idx = STEP_DATA0 + n_data;
        for (int i = STEP_PRESTOP; i <= last_idx; i++) begin
            stop_wait = (i == STEP_PRESTOP) || (i == last_idx);
            // stray words the current wait must ignore
            if (noise_on && $urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 2) == 0)
                    stray = any_item(CMD_BEGIN);
                else
                    stray = any_item(stop_wait ? CMD_STATUS : CMD_STOPPED);
                send_word(stray, 1'b0);
            end
            if (i != fault_at && timeout_now >= 2 && $urandom_range(0, 3) == 0) begin
                hi = (timeout_now > 4) ? 3 : int'(timeout_now) - 1;
                send_ticks($urandom_range(1, hi));
            end
            if (i == fault_at) begin
                if (!stop_wait && kind == FLT_BAD_STATUS) begin
                    st = 8'($urandom_range(0, 255));
                    if (st inside {ST_START_SENT, ST_RSTART_SENT, ST_SLA_W_ACK,
                                   ST_SLA_R_ACK, ST_RX_ACK, ST_RX_NACK, ST_TX_ACK})
                        st[7] = 1'b1;
                    send_status(st);
                end else begin
                    send_ticks((timeout_now == '0) ? 1 : int'(timeout_now));
                end
                if (!stop_wait)
                    send_word(any_item(CMD_STOPPED), 1'b1);
                return;
            end
            if (stop_wait) begin
                send_word(any_item(CMD_STOPPED), 1'b1);
            end else begin
                case (i)
                    STEP_START: st = $urandom_range(0, 1) ? ST_START_SENT : ST_RSTART_SENT;
                    STEP_ADDR:  st = $urandom_range(0, 1) ? ST_SLA_W_ACK : ST_SLA_R_ACK;
                    default:    st = !rnw ? ST_TX_ACK :
                                     ($urandom_range(0, 1) ? ST_RX_ACK : ST_RX_NACK);
                endcase
                send_status(st);
            end
        end
    endtask

    task automatic random_transfers(input int budget);
        int          stop_at;
        int          r;
        int          n_data;
        int          fault_at;
        logic [15:0] len;
        t_fault      kind;
        stop_at = words_sent + budget;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 5) == 0) begin
                r = $urandom_range(0, 3);
                if (r == 0)
                    send_zero_begin();
                else
                    send_word(any_item(r[1:0]), 1'b0);
            end
            r = $urandom_range(0, 99);
            if (r < 88)
                len = 16'($urandom_range(1, 6));
            else if (r < 93)
                len = 16'($urandom_range(7, MAX_DATA));
            else
                len = 16'($urandom_range(0, 65535));
            n_data   = (int'(len) > MAX_DATA) ? MAX_DATA : int'(len);
            fault_at = 0;
            kind     = FLT_BAD_STATUS;
            // long transfers are always cut short by a fault
            if (int'(len) > MAX_DATA || $urandom_range(0, 3) == 0) begin
                kind = $urandom_range(0, 1) ? FLT_TIMEOUT : FLT_BAD_STATUS;
                if (timeout_now > 20)
                    kind = FLT_BAD_STATUS;
                if (kind == FLT_BAD_STATUS)
                    fault_at = $urandom_range(STEP_START, STEP_DATA0 + n_data - 1);
                else
                    fault_at = $urandom_range(STEP_PRESTOP, STEP_DATA0 + n_data -
                                              int'(int'(len) > MAX_DATA));
            end
            run_transfer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), len,
                         fault_at, kind);
        end
    endtask

    // receiver: random stalls, plus one long hold-off once the random part starts
    initial begin : drain
        bit hold_done;
        bit steady;
        int stall;
        hold_done = 1'b0;
        steady    = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                if ($urandom_range(0, 29) == 0)
                    steady = !steady;
                stall = pick_gap(steady);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int budget;
        tmo_plan = '{10, 1, 255, 0, 0, 0};
        tmo_plan[4] = $urandom_range(2, 20);
        tmo_plan[5] = $urandom_range(2, 20);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle events, zero length, a clean write, a clean read, an aborted long read
        send_word(any_item(CMD_TICK), 1'b0);
        send_zero_begin();
        send_word(any_item(CMD_STATUS), 1'b0);
        run_transfer(8'hFE, 1'b0, 16'd1, 0, FLT_BAD_STATUS);
        send_zero_begin();
        run_transfer(8'h00, 1'b1, 16'd2, 0, FLT_BAD_STATUS);
        run_transfer(8'hFF, 1'b1, 16'hFFFF, STEP_ADDR, FLT_BAD_STATUS);
        wait_idle();

        noise_on     = 1'b1;
        hold_off_req = 1'b1;
        for (int p = 0; p < N_SETTINGS; p++) begin
            if (p > 0)
                set_timeout(8'(tmo_plan[p]));
            // share what is left of the word budget over the remaining settings
            budget = (WORD_BUDGET - words_sent) / (N_SETTINGS - p);
            random_transfers(budget);
            // ride one stop wait all the way to the largest timeout
            if (timeout_now == 8'd255)
                run_transfer(8'($urandom_range(0, 255)), 1'b0, 16'd2, STEP_DATA0 + 2,
                             FLT_TIMEOUT);
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d step words over %0d timeout settings (0 to 255).",
                 checked, N_SETTINGS);
        $display("Transfers ended with ack: %0d, without ack: %0d.", acked, failed);
        if (errors == 0)
            $display("i2c_master_transaction_sequencer_core test passed");
        else
            $display("i2c_master_transaction_sequencer_core test failed");
        $finish;
    end

endmodule
